[rtl/cqd_pkg.sv]
package cqd_pkg;

   localparam int DEPTH        = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int CAP_LIMIT    = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;

   localparam int WORD_W  = 32;
   localparam int CFG_W   = 5;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int PTR_W   = IDX_W + 1;
   localparam int CAP_W   = $clog2(CAP_LIMIT + 1);

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_VIEW = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CAP_W-1:0] cap_type;

   // zero acts as one, anything above the usable limit saturates
   function automatic cap_type clamp_cap(input logic [CFG_W-1:0] v);
      cap_type r;
      if (v == '0) begin
         r = cap_type'(1);
      end else if (v > CFG_W'(CAP_LIMIT)) begin
         r = cap_type'(CAP_LIMIT);
      end else begin
         r = cap_type'(v);
      end
      return r;
   endfunction

   // index plus one, wrapping at the capacity in use
   function automatic idx_type wrap_inc(input idx_type i, input cap_type cap);
      logic [PTR_W-1:0] s;
      s = {1'b0, i} + PTR_W'(1);
      if (s == PTR_W'(cap)) begin
         return '0;
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

[rtl/cqd_ram.sv]
module cqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/circular_queue_with_dump.sv]
// Circular queue of signed 32-bit words with a dump of its contents after every operation.
// Input: an operation is accepted at a clock edge with start high and busy low;
// req_mode selects push (req_push_value stored at the tail), pop (head dropped)
// or view. Mode 3 is ignored and gives no results.
// Output: each operation lists the queue from head to tail, one result per
// stored word, each shown for one cycle with rsp_strobe high and the last one
// marked by rsp_last. An empty queue gives one result with rsp_is_empty set.
// rsp_status is the same on every result of an operation (done, full, empty).
// Timing: the accepting edge moves the block to its dump state, where the read
// data and the strobe are registered together; the results follow one per cycle
// and busy drops after the last one. The rate is set by the single read port of
// the slot memory, walked by one index unit.
// Configuration: csr_wr_en with csr_wr_data sets the capacity (0 acts as 1,
// large values saturate at the built depth) and empties the queue; write only
// while busy is low. Reset empties the queue and sets the capacity to its max.
// The receiver cannot hold results off; every strobe is a transfer.
module circular_queue_with_dump (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic signed [cqd_pkg::WORD_W-1:0] req_push_value,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_is_empty,
   output logic signed [cqd_pkg::WORD_W-1:0] rsp_element,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [cqd_pkg::CFG_W-1:0]    csr_wr_data
);

   import cqd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DUMP = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   idx_type     head_ff, head_in;
   idx_type     tail_ff, tail_in;
   idx_type     pos_ff, pos_in;
   logic        holds_ff, holds_in;
   cap_type     cap_ff, cap_in;
   logic        strobe_ff, strobe_in;
   logic        last_ff, last_in;
   logic        empty_ff, empty_in;
   logic [1:0]  status_ff, status_in;

   logic        accept;
   logic        op_valid;
   idx_type     inc_arg;
   idx_type     inc_out;
   logic        wr_en;
   idx_type     wr_addr;
   logic [WORD_W-1:0] rd_data;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;

   // the one shared wrap-around incrementer
   assign inc_arg = (state_ff == S_DUMP) ? pos_ff
                  : ((req_mode == MODE_PUSH) ? tail_ff : head_ff);
   assign inc_out = wrap_inc(inc_arg, cap_ff);

   always_comb begin
      op_valid  = accept & (req_mode inside {MODE_PUSH, MODE_POP, MODE_VIEW});
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      pos_in    = pos_ff;
      holds_in  = holds_ff;
      cap_in    = cap_ff;
      strobe_in = 1'b0;
      last_in   = 1'b0;
      empty_in  = empty_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = inc_out;

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               status_in = ST_DONE;
               case (req_mode)
                  MODE_PUSH: begin
                     if (!holds_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        holds_in = 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                     end else if (inc_out == head_ff) begin
                        status_in = ST_FULL;
                     end else begin
                        tail_in = inc_out;
                        wr_en   = 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (!holds_ff) begin
                        status_in = ST_EMPTY;
                     end else if (head_ff == tail_ff) begin
                        head_in  = '0;
                        tail_in  = '0;
                        holds_in = 1'b0;
                     end else begin
                        head_in = inc_out;
                     end
                  end
                  default: begin
                  end
               endcase
               pos_in   = head_in;
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            strobe_in = 1'b1;
            if (!holds_ff) begin
               last_in  = 1'b1;
               empty_in = 1'b1;
               state_in = S_WAIT;
            end else begin
               // read issued at pos_ff, data shows up with the strobe next cycle
               empty_in = 1'b0;
               last_in  = (pos_ff == tail_ff);
               pos_in   = inc_out;
               if (pos_ff == tail_ff) begin
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write empties the queue
      if (csr_wr_en) begin
         cap_in   = clamp_cap(csr_wr_data);
         head_in  = '0;
         tail_in  = '0;
         holds_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         holds_ff  <= 1'b0;
         cap_ff    <= clamp_cap(CFG_W'(RESULT_LIMIT));
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         holds_ff  <= holds_in;
         cap_ff    <= cap_in;
         strobe_ff <= strobe_in;
      end
      pos_ff    <= pos_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
      status_ff <= status_in;
   end

   cqd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_is_empty = empty_ff;
   assign rsp_last     = last_ff;
   assign rsp_element  = empty_ff ? '0 : $signed(rd_data);

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transfer outside an operation");

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe && !busy)
      else $error("results continue after last");

   a_empty_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_empty |-> rsp_last)
      else $error("empty result not marked last");

   a_op_starts : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_PUSH || req_mode == MODE_POP
                         || req_mode == MODE_VIEW) |=> busy)
      else $error("accepted operation did not start");

endmodule

[verif/queue_dump_checker.sv]
module queue_dump_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_mode,
   input  logic signed [cqd_pkg::WORD_W-1:0] req_push_value,
   input  logic                              rsp_strobe,
   input  logic [1:0]                        rsp_status,
   input  logic                              rsp_is_empty,
   input  logic signed [cqd_pkg::WORD_W-1:0] rsp_element,
   input  logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [cqd_pkg::CFG_W-1:0]         csr_wr_data,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import cqd_pkg::*;

   typedef struct packed {
      logic [1:0]               status;
      logic                     is_empty;
      logic signed [WORD_W-1:0] element;
      logic                     last;
   } dump_entry_type;

   dump_entry_type           dump_expect [$];
   logic signed [WORD_W-1:0] model_slots [DEPTH];
   int unsigned              model_head;
   int unsigned              model_tail;
   bit                       model_holds;
   logic [CFG_W-1:0]         model_capacity;
   int                       errors = 0;
   int                       owed = 0;

   assign mismatch_count = errors;
   assign pending_count  = owed;

   function automatic int unsigned usable_capacity();
      int unsigned c;
      c = model_capacity;
      if (c < 1) begin
         c = 1;
      end
      if (c > CAP_LIMIT) begin
         c = CAP_LIMIT;
      end
      return c;
   endfunction

   function automatic void clear_queue();
      model_head  = 0;
      model_tail  = 0;
      model_holds = 1'b0;
   endfunction

   // one entry per stored word, head first; an empty queue lists as a single entry
   function automatic void queue_dump(input logic [1:0] status);
      int unsigned cap;
      int unsigned count;
      int unsigned pos;
      dump_entry_type e;
      cap = usable_capacity();
      if (!model_holds) begin
         e = '{status: status, is_empty: 1'b1, element: '0, last: 1'b1};
         dump_expect.push_back(e);
         return;
      end
      count = ((model_tail + cap - model_head) % cap) + 1;
      pos = model_head;
      for (int unsigned k = 0; k < count; k++) begin
         e = '{status: status, is_empty: 1'b0, element: model_slots[pos % DEPTH],
               last: (k + 1 == count)};
         dump_expect.push_back(e);
         pos = (pos + 1) % cap;
      end
   endfunction

   function automatic void predict_dump(input logic [1:0] mode,
                                        input logic signed [WORD_W-1:0] word);
      int unsigned cap;
      logic [1:0]  status;
      cap = usable_capacity();
      status = ST_DONE;
      case (mode)
         MODE_PUSH: begin
            if (!model_holds) begin
               model_head = 0;
               model_tail = 0;
               model_holds = 1'b1;
               model_slots[0] = word;
            end else if ((model_tail + 1) % cap == model_head) begin
               status = ST_FULL;
            end else begin
               model_tail = (model_tail + 1) % cap;
               model_slots[model_tail % DEPTH] = word;
            end
         end
         MODE_POP: begin
            if (!model_holds) begin
               status = ST_EMPTY;
            end else if (model_head == model_tail) begin
               clear_queue();
            end else begin
               model_head = (model_head + 1) % cap;
            end
         end
         MODE_VIEW: begin
         end
         default: begin
            return;
         end
      endcase
      queue_dump(status);
   endfunction

   always @(posedge clock) begin
      dump_entry_type e;
      if (reset) begin
         dump_expect.delete();
         foreach (model_slots[i]) model_slots[i] = '0;
         clear_queue();
         model_capacity = CFG_W'(16);
      end else begin
         if (rsp_strobe) begin
            if (dump_expect.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t unexpected result: status=%0d empty=%0b element=%0d last=%0b",
                           $realtime, rsp_status, rsp_is_empty, rsp_element,
                           rsp_last);
               end
            end else begin
               e = dump_expect.pop_front();
               if (rsp_status !== e.status || rsp_is_empty !== e.is_empty ||
                   rsp_element !== e.element || rsp_last !== e.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t mismatch exp status=%0d empty=%0b element=%0d last=%0b",
                              $realtime, e.status, e.is_empty, e.element, e.last);
                     $display("%0t          got status=%0d empty=%0b element=%0d last=%0b",
                              $realtime, rsp_status, rsp_is_empty, rsp_element,
                              rsp_last);
                  end
               end
            end
         end
         // a capacity write also empties the queue
         if (csr_wr_en) begin
            model_capacity = csr_wr_data;
            clear_queue();
         end
         if (start && !busy) begin
            predict_dump(req_mode, req_push_value);
         end
      end
      owed = dump_expect.size();
   end

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cqd_pkg::*;

   localparam logic [1:0] MODE_SKIP = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_mode = MODE_VIEW;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic                     rsp_is_empty;
   logic signed [WORD_W-1:0] rsp_element;
   logic                     rsp_last;
   logic                     csr_wr_en = 1'b0;
   logic [CFG_W-1:0]         csr_wr_data = '0;
   int                       dump_errors;
   int                       dumps_owed;
   bit                       no_idle = 1'b0;

   always #5 clock = ~clock;

   circular_queue_with_dump dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_element    (rsp_element),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   queue_dump_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_element    (rsp_element),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (dump_errors),
      .pending_count  (dumps_owed)
   );

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_op(input logic [1:0] mode, input logic signed [WORD_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // wait until every listed word has arrived and the block is idle
   task automatic settle();
      start <= 1'b0;
      while (dumps_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CFG_W-1:0] cap);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int phase_caps [8];
      int counted;
      int push_pct;
      int r;
      phase_caps = '{16, 1, 0, 31, 2, 0, 7, 0};
      phase_caps[5] = $urandom_range(3, 15);
      phase_caps[7] = $urandom_range(17, 30);

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity: empty cases, extremes of the word, pop back to empty
      send_op(MODE_VIEW, '0);
      send_op(MODE_POP, '0);
      send_op(MODE_SKIP, 32'sh1234_5678);
      send_op(MODE_PUSH, 32'sh8000_0000);
      send_op(MODE_PUSH, 32'sh7fff_ffff);
      send_op(MODE_VIEW, '0);
      send_op(MODE_POP, '0);
      send_op(MODE_POP, '0);
      send_op(MODE_POP, '0);

      // two slots: full refusal and tail wrap
      write_capacity(CFG_W'(2));
      send_op(MODE_PUSH, '0);
      send_op(MODE_PUSH, '1);
      send_op(MODE_PUSH, 32'sh5555_5555);
      send_op(MODE_POP, '0);
      send_op(MODE_PUSH, 32'shaaaa_aaaa);
      send_op(MODE_VIEW, '0);
      send_op(MODE_PUSH, 32'sh0f0f_0f0f);

      // zero capacity acts as a single slot
      write_capacity(CFG_W'(0));
      send_op(MODE_PUSH, 32'sh0000_0001);
      send_op(MODE_PUSH, 32'sh0000_0002);
      send_op(MODE_POP, '0);
      send_op(MODE_VIEW, '0);

      foreach (phase_caps[p]) begin
         write_capacity(CFG_W'(phase_caps[p]));
         counted = 0;
         while (counted < 50) begin
            // alternate fill and drain so both full and empty are reached
            push_pct = ((counted / 12) % 2 == 0) ? 75 : 28;
            no_idle = ((counted / 18) % 3 == 2);
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_op(MODE_SKIP, pick_word());
            end else begin
               if (r < 14) begin
                  send_op(MODE_VIEW, pick_word());
               end else if (r < 14 + push_pct * 86 / 100) begin
                  send_op(MODE_PUSH, pick_word());
               end else begin
                  send_op(MODE_POP, pick_word());
               end
               counted++;
            end
         end
         no_idle = 1'b0;
      end

      settle();
      repeat (20) @(negedge clock);
      if (dump_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
